// File: src/cqs_pkg.sv
// Package for the circular queue with search: request/result types, codes, sequencer states.
package cqs_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [1:0] REQ_SEARCH  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] data_out;
    logic        [3:0]  position;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

endpackage

// File: src/circular_queue_with_search.sv
// Circular FIFO of signed 32-bit values with dequeue and head-to-tail search.
//
// A request transfers when start is high and busy is low; its result appears on result for
// one cycle with done high, and the receiver cannot stall it. Enqueue, and any request that
// fails at once (full, empty, unused kind), gives its result the cycle after the transfer
// without raising busy, so one such request can follow every cycle. Dequeue holds busy for
// one cycle, during which no new request transfers. A search holds busy while it compares
// entries from head toward tail and ends at the first match or after the last stored entry.
// Its pace is set by the single registered read port of the slot memory, which feeds one
// entry per cycle to one shared equality compare.
module circular_queue_with_search #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cqs_pkg::request_t  request,
  output logic               done,
  output cqs_pkg::result_t   result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Slot memory, one write and one registered read per cycle
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [IW-1:0]      rd_addr;

  cqs_pkg::state_t state, state_next;

  logic [IW-1:0] head, tail;
  logic [CW-1:0] occupancy;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] issued;
  logic [CW-1:0] checked;
  logic          rd_vld;
  logic signed [31:0] key;

  logic accept, is_full, is_empty, wr_en, scan_issue, hit, last;
  logic [3:0] pos_wide;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  assign accept   = start && !busy;
  assign is_full  = (occupancy == CW'(DEPTH));
  assign is_empty = (occupancy == '0);
  assign wr_en    = accept && (request.req_type == cqs_pkg::REQ_ENQUEUE) && !is_full;
  assign hit      = rd_vld && (rd_data == key);
  assign last     = (checked + CW'(1)) == occupancy;
  assign pos_wide = 4'(checked) + 4'd1;

  // Memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= request.value;
    end
    rd_data <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cqs_pkg::S_IDLE: begin
        if (accept && !is_empty && request.req_type == cqs_pkg::REQ_DEQUEUE) begin
          state_next = cqs_pkg::S_DEQ;
        end else if (accept && !is_empty && request.req_type == cqs_pkg::REQ_SEARCH) begin
          state_next = cqs_pkg::S_SCAN;
        end
      end
      cqs_pkg::S_DEQ: state_next = cqs_pkg::S_IDLE;
      cqs_pkg::S_SCAN: begin
        if (rd_vld && (hit || last)) begin
          state_next = cqs_pkg::S_IDLE;
        end
      end
      default: state_next = cqs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy       = 1'b0;
    rd_addr    = head;
    scan_issue = 1'b0;
    unique case (state)
      cqs_pkg::S_IDLE: begin
        rd_addr = head;
      end
      cqs_pkg::S_DEQ: begin
        busy = 1'b1;
      end
      cqs_pkg::S_SCAN: begin
        busy       = 1'b1;
        rd_addr    = rd_ptr;
        scan_issue = issued < occupancy;
      end
      default: busy = 1'b0;
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cqs_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      rd_vld    <= 1'b0;
      issued    <= '0;
      checked   <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        cqs_pkg::S_IDLE: begin
          if (accept) begin
            result.status   <= cqs_pkg::ST_OK;
            result.data_out <= '0;
            result.position <= '0;
            key             <= request.value;
            case (request.req_type)
              cqs_pkg::REQ_ENQUEUE: begin
                done <= 1'b1;
                if (is_full) begin
                  result.status <= cqs_pkg::ST_FULL;
                end else begin
                  tail      <= next_idx(tail);
                  occupancy <= occupancy + CW'(1);
                end
              end
              cqs_pkg::REQ_DEQUEUE: begin
                if (is_empty) begin
                  result.status <= cqs_pkg::ST_EMPTY;
                  done          <= 1'b1;
                end else begin
                  head      <= next_idx(head);
                  occupancy <= occupancy - CW'(1);
                end
              end
              cqs_pkg::REQ_SEARCH: begin
                if (is_empty) begin
                  result.status <= cqs_pkg::ST_EMPTY;
                  done          <= 1'b1;
                end else begin
                  // head entry is being read at this edge
                  rd_ptr  <= next_idx(head);
                  issued  <= CW'(1);
                  checked <= '0;
                  rd_vld  <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        cqs_pkg::S_DEQ: begin
          result.data_out <= rd_data;
          done            <= 1'b1;
        end
        cqs_pkg::S_SCAN: begin
          // keep one read ahead of the compare
          if (scan_issue) begin
            rd_ptr <= next_idx(rd_ptr);
            issued <= issued + CW'(1);
          end
          rd_vld <= scan_issue;
          if (rd_vld) begin
            if (hit) begin
              result.status   <= cqs_pkg::ST_OK;
              result.position <= pos_wide;
              done            <= 1'b1;
              rd_vld          <= 1'b0;
            end else if (last) begin
              result.status <= cqs_pkg::ST_NOT_FOUND;
              done          <= 1'b1;
              rd_vld        <= 1'b0;
            end else begin
              checked <= checked + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/cqs_checker.sv
// Port-level checker for the circular queue with search, bound to the top level.
module cqs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input cqs_pkg::request_t request,
  input logic              done,
  input cqs_pkg::result_t  result
);

  // Every transfer either starts work or answers on the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transfer neither busy nor answered");

  // A result only follows a transfer or a busy cycle
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> ($past(busy) || $past(start && !busy)))
    else $error("result with no request behind it");

  // Ending a multi-cycle request always delivers its result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  // Returned data and position only come with an ok status, never both
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (result.data_out != 0 || result.position != 0)) |->
      (result.status == cqs_pkg::ST_OK && (result.data_out == 0 || result.position == 0)))
    else $error("payload inconsistent with status");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
